/* rtl/gamepad_input_report_composer_defines.svh */
// Assertion macros for the gamepad input report composer.
`ifndef GAMEPAD_INPUT_REPORT_COMPOSER_DEFINES_SVH
`define GAMEPAD_INPUT_REPORT_COMPOSER_DEFINES_SVH
// Assert that a condition implies a property in the same cycle.
`define GIRC_ASSERT_IMP(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Assert that a condition implies a property in the next cycle.
`define GIRC_ASSERT_NXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

/* rtl/girc_pkg.sv */
// Package: constants, types and helper functions of the report composer.
package girc_pkg;
    localparam int unsigned WindowLen = 30;
    localparam logic [7:0]  TrigThrRst = 8'd225;
    localparam logic [15:0] PeriodRst = 16'd4096;
    localparam logic [31:0] RangeLimit = 32'd1000000;
    localparam logic [7:0]  ReportId = 8'h01;
    localparam logic [7:0]  PadByte = 8'h80;
    localparam int unsigned DeltaW = 20;
    localparam int unsigned SumW = 25;
    localparam int unsigned QuoW = 64;

    localparam logic [0:0] RegTrig = 1'b0;
    localparam logic [0:0] RegPeriod = 1'b1;

    typedef struct packed {
        logic [62:0] time_us;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [7:0]  left_trigger;
        logic [7:0]  right_trigger;
        logic [14:0] buttons;
        logic [7:0]  hat_code;
        logic [47:0] gyro_packed;
        logic [47:0] accel_packed;
    } t_in;

    typedef struct packed {
        logic [63:0] report_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    function automatic logic [3:0] hat_value(input logic [7:0] code);
        logic [3:0] v;
        case (code)
            8'h01:   v = 4'd2;
            8'h02:   v = 4'd6;
            8'h10:   v = 4'd0;
            8'h20:   v = 4'd4;
            8'h11:   v = 4'd1;
            8'h12:   v = 4'd7;
            8'h21:   v = 4'd3;
            8'h22:   v = 4'd5;
            default: v = 4'd8;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] stick_byte(input logic [15:0] raw);
        return {~raw[15], raw[14:8]};
    endfunction
endpackage

/* rtl/girc_if.sv */
// Valid/ready channel interface carrying one payload.
interface girc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/gamepad_input_report_composer.sv */
// Top level of the gamepad input report composer.
// Channel   | Dir | Payload                                   | Handshake
// in_ch     | in  | one snapshot request (time, sticks, ...)  | valid/ready
// out_ch    | out | report_word, word_index, last_word        | valid/ready
// apb       | in  | trigger_threshold, nominal_period         | psel/penable
// Each request passes through the accept state, a ring read wait, the ring
// update with mag*period, the multiply by WINDOW_LEN, a 64-step restoring
// divider one quotient bit per cycle, the timestamp, then eight output words,
// one per cycle when the sink is ready.
// After reset, a clearing pass zeroes the delta ring;
// no request is taken meanwhile. Output stalls hold the current word.
`include "gamepad_input_report_composer_defines.svh"
module gamepad_input_report_composer #(
    parameter int unsigned WINDOW_LEN = girc_pkg::WindowLen
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    girc_if.sink        in_ch,
    girc_if.source      out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned PosW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [PosW-1:0] PosLast = PosW'(WINDOW_LEN - 1);
    localparam logic [7:0] WinLen8 = 8'(WINDOW_LEN);
    // Width of the sum of a full window of in-range deltas.
    localparam int unsigned SumW = $clog2(WINDOW_LEN * 999999 + 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_UPD   = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_TS    = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [7:0]  r_thr;
    logic [15:0] r_period;
    logic        wr_en;
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= girc_pkg::TrigThrRst;
            r_period <= girc_pkg::PeriodRst;
        end else if (wr_en && paddr[1:0] == 2'b00) begin
            if (paddr[2] == girc_pkg::RegTrig) begin
                r_thr <= pwdata[7:0];
            end else begin
                r_period <= pwdata[15:0];
            end
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[2] == girc_pkg::RegTrig) begin
            prdata = {24'd0, r_thr};
        end else begin
            prdata = {16'd0, r_period};
        end
    end

    // Scalar state.
    logic [7:0]  r_seq;
    logic [31:0] r_zero_cnt;
    logic [62:0] r_prev;
    logic [SumW-1:0] r_sum;
    logic [PosW-1:0] r_pos;
    logic [63:0] r_synth;

    // Captured request and working registers.
    girc_pkg::t_in r_item;
    logic [31:0] r_delta;
    logic [31:0] r_mag;
    logic        r_neg;
    logic        r_inr;
    logic [47:0] r_prod;
    logic [63:0] r_rem_num;
    logic [SumW:0] r_rem;
    logic [63:0] r_quo;
    logic [6:0]  r_cnt;
    logic [31:0] r_ts;
    logic [2:0]  r_word;

    // Delta ring memory.
    logic               ram_we;
    logic [PosW-1:0]    ram_addr;
    logic [19:0]        ram_wdata;
    logic [19:0]        ram_rdata;
    girc_ram #(.Width(girc_pkg::DeltaW), .Depth(WINDOW_LEN)) u_ring (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    always_comb begin
        ram_we = 1'b0;
        ram_addr = r_pos;
        ram_wdata = r_delta[19:0];
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
            ram_wdata = '0;
        end else if (r_state == S_UPD) begin
            ram_we = r_inr;
        end
    end

    // Delta of the incoming request, low 32 bits.
    logic [31:0] in_delta;
    assign in_delta = 32'(in_ch.data.time_us) - 32'(r_prev);

    assign in_ch.ready = (r_state == S_IDLE);

    // One restoring divide step.
    logic [SumW:0] div_try;
    logic [SumW:0] div_sub;
    assign div_try = {r_rem[SumW-1:0], r_rem_num[63]};
    assign div_sub = div_try - {1'b0, r_sum};

    logic [SumW-1:0] new_sum;
    assign new_sum = r_sum - SumW'(ram_rdata) + SumW'(r_delta);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_seq <= '0;
            r_zero_cnt <= '0;
            r_prev <= '0;
            r_sum <= '0;
            r_pos <= '0;
            r_synth <= '0;
            r_word <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    // Sweep the ring to zero.
                    if (r_pos == PosLast) begin
                        r_pos <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_item <= in_ch.data;
                        r_delta <= in_delta;
                        r_neg <= in_delta[31];
                        r_mag <= in_delta[31] ? (32'd0 - in_delta) : in_delta;
                        r_inr <= (in_delta != 0) && !in_delta[31]
                                 && (in_delta < girc_pkg::RangeLimit);
                        r_prev <= in_ch.data.time_us;
                        if (in_delta == 0) begin
                            r_zero_cnt <= r_zero_cnt + 1'b1;
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // Wait for ring read data.
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    // Replace the oldest delta and advance if in range; form mag*period.
                    if (r_inr) begin
                        r_sum <= new_sum;
                        r_pos <= (r_pos == PosLast) ? '0 : r_pos + 1'b1;
                    end
                    r_prod <= 48'(r_mag) * 48'(r_period);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_rem_num <= {16'd0, r_prod} * 64'(WinLen8);
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem_num <= {r_rem_num[62:0], 1'b0};
                    if (!div_sub[SumW]) begin
                        r_rem <= div_sub;
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= div_try;
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 7'd63) begin
                        r_state <= S_TS;
                    end
                end
                S_TS: begin
                    logic [63:0] s;
                    s = r_synth;
                    if (r_delta != 0 && r_sum != 0) begin
                        s = r_neg ? r_synth - r_quo : r_synth + r_quo;
                    end
                    r_synth <= s;
                    r_ts <= s[31:0] + 32'(r_zero_cnt * {16'd0, r_period});
                    r_word <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Advance one word per accepted result.
                    if (out_ch.ready) begin
                        r_word <= r_word + 1'b1;
                        if (r_word == 3'd7) begin
                            r_seq <= r_seq + 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Report bytes of the current word.
    logic [7:0] b9;
    logic [63:0] word_val;
    always_comb begin
        b9 = {r_item.buttons[9:6], r_item.right_trigger >= r_thr,
              r_item.left_trigger >= r_thr, r_item.buttons[5:4]};
        case (r_word)
            3'd0: word_val = {r_seq, r_item.right_trigger, r_item.left_trigger,
                              girc_pkg::stick_byte(r_item.right_y),
                              girc_pkg::stick_byte(r_item.right_x),
                              girc_pkg::stick_byte(r_item.left_y),
                              girc_pkg::stick_byte(r_item.left_x),
                              girc_pkg::ReportId};
            3'd1: word_val = {40'd0, r_item.buttons[13:10], 3'd0, r_item.buttons[14],
                              b9, r_item.buttons[3:0],
                              girc_pkg::hat_value(r_item.hat_code)};
            3'd2: word_val = {r_item.accel_packed[15:0],
                              16'd0 - r_item.gyro_packed[47:32],
                              16'd0 - r_item.gyro_packed[31:16], r_item.gyro_packed[15:0]};
            3'd3: word_val = {r_ts, 16'd0 - r_item.accel_packed[47:32],
                              16'd0 - r_item.accel_packed[31:16]};
            3'd4: word_val = {32'd0, girc_pkg::PadByte, 24'd0};
            3'd5: word_val = {24'd0, girc_pkg::PadByte, 32'd0};
            3'd6: word_val = {16'd0, girc_pkg::PadByte, 32'd0, girc_pkg::PadByte};
            default: word_val = {8'd0, girc_pkg::PadByte, 32'd0, girc_pkg::PadByte, 8'd0};
        endcase
    end

    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.data.report_word = word_val;
    assign out_ch.data.word_index = r_word;
    assign out_ch.data.last_word = (r_word == 3'd7);

    `GIRC_ASSERT_IMP(a_no_in_when_busy, i_clk, i_rst_n, r_state != S_IDLE, !in_ch.ready)
    `GIRC_ASSERT_IMP(a_out_only_out, i_clk, i_rst_n, out_ch.valid, r_state == S_OUT)
    `GIRC_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n,
        out_ch.valid && out_ch.ready && out_ch.data.last_word, r_state == S_IDLE)
endmodule

/* rtl/girc_ram.sv */
// Generic single-port synchronous RAM with registered read.
module girc_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] i_addr,
    input  logic [Width-1:0]                            i_wdata,
    output logic [Width-1:0]                            o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* tb/sv/girc_report_checker.sv */
// Report checker: predicts each report from the snapshot requests and compares words.
`timescale 1ns / 1ps
module girc_report_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  girc_pkg::t_in  in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  girc_pkg::t_out out_data,
    input  logic [7:0]  trig_thr,
    input  logic [15:0] period,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words_seen
);
    import girc_pkg::*;

    t_out        words_due[$];
    logic [7:0]  seq_cnt;
    logic [31:0] zero_cnt;
    logic [63:0] prev_time;
    logic [31:0] ring [WindowLen];
    logic [31:0] ring_sum;
    int unsigned ring_pos;
    logic [63:0] synth_time;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        o_fail_count++;
    endtask

    function automatic logic [15:0] neg16(input logic [15:0] v);
        return 16'h0000 - v;
    endfunction

    task automatic compose_report(input t_in s);
        logic [7:0]  b [64];
        logic [31:0] d, mag, ts;
        logic        neg;
        logic [63:0] q, w;
        logic [3:0]  hv;
        t_out        o;
        d = s.time_us - prev_time[62:0];
        neg = d[31];
        mag = neg ? 32'd0 - d : d;
        prev_time = {1'b0, s.time_us};
        if (d == 0) begin
            zero_cnt++;
        end else if (!neg && d < RangeLimit) begin
            ring_sum = ring_sum - ring[ring_pos] + d;
            ring[ring_pos] = d;
            ring_pos = (ring_pos + 1 >= WindowLen) ? 0 : ring_pos + 1;
        end
        if (d != 0 && ring_sum != 0) begin
            q = (64'(mag) * 64'(period) * 64'(WindowLen)) / 64'(ring_sum);
            synth_time = neg ? synth_time - q : synth_time + q;
        end
        ts = 32'(synth_time + 64'(zero_cnt) * 64'(period));
        foreach (b[i]) b[i] = 8'h00;
        b[0] = ReportId;
        b[1] = 8'((16'(s.left_x) + 16'h8000) >> 8);
        b[2] = 8'((16'(s.left_y) + 16'h8000) >> 8);
        b[3] = 8'((16'(s.right_x) + 16'h8000) >> 8);
        b[4] = 8'((16'(s.right_y) + 16'h8000) >> 8);
        b[5] = s.left_trigger;
        b[6] = s.right_trigger;
        b[7] = seq_cnt;
        seq_cnt++;
        case (s.hat_code)
            8'h01: hv = 2;  8'h02: hv = 6;  8'h10: hv = 0;  8'h20: hv = 4;
            8'h11: hv = 1;  8'h12: hv = 7;  8'h21: hv = 3;  8'h22: hv = 5;
            default: hv = 8;
        endcase
        b[8] = {s.buttons[3:0], hv};
        b[9] = {s.buttons[9:6], s.right_trigger >= trig_thr,
                s.left_trigger >= trig_thr, s.buttons[5:4]};
        b[10] = {s.buttons[13:10], 3'b000, s.buttons[14]};
        {b[17], b[16]} = s.gyro_packed[15:0];
        {b[19], b[18]} = neg16(s.gyro_packed[31:16]);
        {b[21], b[20]} = neg16(s.gyro_packed[47:32]);
        {b[23], b[22]} = s.accel_packed[15:0];
        {b[25], b[24]} = neg16(s.accel_packed[31:16]);
        {b[27], b[26]} = neg16(s.accel_packed[47:32]);
        {b[31], b[30], b[29], b[28]} = ts;
        b[35] = PadByte; b[44] = PadByte; b[48] = PadByte;
        b[53] = PadByte; b[57] = PadByte; b[62] = PadByte;
        for (int k = 0; k < 8; k++) begin
            for (int j = 7; j >= 0; j--) w = {w[55:0], b[k * 8 + j]};
            o.report_word = w;
            o.word_index = 3'(k);
            o.last_word = (k == 7);
            words_due.push_back(o);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            seq_cnt = 0; zero_cnt = 0; prev_time = 0; ring_sum = 0;
            ring_pos = 0; synth_time = 0;
            foreach (ring[i]) ring[i] = 0;
            words_due.delete();
            o_fail_count = 0;
            o_words_seen = 0;
        end else begin
            // check output first: a request never yields a word in the same cycle
            if (out_valid && out_ready) begin
                o_words_seen++;
                if (words_due.size() == 0) begin
                    report_mismatch("unexpected word", out_data.report_word, 0);
                end else begin
                    want = words_due.pop_front();
                    if (out_data.report_word !== want.report_word)
                        report_mismatch($sformatf("word %0d", want.word_index),
                                        out_data.report_word, want.report_word);
                    if (out_data.word_index !== want.word_index)
                        report_mismatch("index", out_data.word_index, want.word_index);
                    if (out_data.last_word !== want.last_word)
                        report_mismatch("last", out_data.last_word, want.last_word);
                end
            end
            if (in_valid && in_ready) compose_report(in_data);
        end
        o_pending = words_due.size();
    end
endmodule

/* tb/sv/tb_gamepad_input_report_composer.sv */
// Testbench top: drives snapshot requests and register writes, gives the verdict.
`timescale 1ns / 1ps
module tb_gamepad_input_report_composer;
    import girc_pkg::*;

    localparam int IdleLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic [7:0]  thr_shadow = TrigThrRst;
    logic [15:0] period_shadow = PeriodRst;
    logic [63:0] time_base = 0;
    int          fail_count, pending, words_seen;
    int          idle_cycles = 0;
    int          req_count = 0;
    bit          calm = 1'b0;

    girc_if #(.T(t_in))  in_ch ();
    girc_if #(.T(t_out)) out_ch ();

    always #2 i_clk = ~i_clk;

    gamepad_input_report_composer dut (
        .i_clk, .i_rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    girc_report_checker checker_i (
        .i_clk, .i_rst_n,
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
        .trig_thr(thr_shadow), .period(period_shadow),
        .o_fail_count(fail_count), .o_pending(pending), .o_words_seen(words_seen)
    );

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // Sink side: stall in random bursts, none once the run turns calm.
    always @(posedge i_clk) begin
        int stall;
        if (i_rst_n && !calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 9);
            out_ch.ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
        end
        out_ch.ready <= 1'b1;
    end

    // Watchdog: count cycles without any accepted request or word.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    // Write one register through the setup and access phases.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        // update the predictor copy once the write has landed
        if (addr == 3'(4 * RegTrig)) thr_shadow = data[7:0];
        else period_shadow = data[15:0];
    endtask

    // Hand one snapshot request to the block; hold valid until accepted.
    task automatic send_snapshot(input t_in s);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= s;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        req_count++;
    endtask

    // Drop valid and wait until every report word has come back.
    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic t_in rand_snapshot(input logic [63:0] t);
        t_in s;
        s.time_us = t[62:0];
        s.left_x = 16'($urandom); s.left_y = 16'($urandom);
        s.right_x = 16'($urandom); s.right_y = 16'($urandom);
        s.left_trigger = 8'($urandom); s.right_trigger = 8'($urandom);
        s.buttons = 15'($urandom);
        case ($urandom_range(0, 9))
            0: s.hat_code = 8'h01; 1: s.hat_code = 8'h02; 2: s.hat_code = 8'h10;
            3: s.hat_code = 8'h20; 4: s.hat_code = 8'h11; 5: s.hat_code = 8'h12;
            6: s.hat_code = 8'h21; 7: s.hat_code = 8'h22;
            default: s.hat_code = 8'($urandom);
        endcase
        s.gyro_packed = {$urandom, $urandom};
        s.accel_packed = {$urandom, $urandom};
        return s;
    endfunction

    // Pick a next time: mostly in-range steps, sometimes zero, backwards or huge.
    function automatic logic [63:0] next_time(input logic [63:0] t);
        case ($urandom_range(0, 11))
            0: return t;
            1: return t - $urandom_range(1, 5000);
            2: return t + 1000000 + $urandom_range(0, 100);
            3: return {1'b0, $urandom, $urandom} >> 1;
            4: return t + 999999;
            default: return t + $urandom_range(1, 8000);
        endcase
    endfunction

    initial begin
        t_in s;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings: field extremes, valid and invalid hat codes,
        // most negative axes, zero, backward and out-of-range deltas.
        s = '0;
        send_snapshot(s);                       // zero delta from reset
        s.left_x = 16'sh8000; s.left_y = 16'sh7fff;
        s.right_x = 16'sh0000; s.right_y = 16'shffff;
        s.left_trigger = 8'd225; s.right_trigger = 8'd224;
        s.buttons = 15'h7fff; s.hat_code = 8'h11;
        s.gyro_packed = 48'h8000_8000_8000; s.accel_packed = 48'h8000_8000_8000;
        s.time_us = 63'd1000;
        send_snapshot(s);
        s.buttons = 15'h0; s.left_trigger = 8'd255; s.right_trigger = 8'd0;
        s.gyro_packed = 48'hffff_ffff_ffff; s.accel_packed = 48'h0001_7fff_0000;
        s.hat_code = 8'hff; s.time_us = 63'd1000;          // zero delta again
        send_snapshot(s);
        s.time_us = 63'd500; s.hat_code = 8'h22;            // backward step
        send_snapshot(s);
        s.time_us = 63'd1500500; s.hat_code = 8'h03;        // out of range
        send_snapshot(s);
        s.time_us = 63'h7fff_ffff_ffff_ffff;
        send_snapshot(s);
        for (int i = 0; i < 10; i++) begin
            time_base = time_base + 4000;
            send_snapshot(rand_snapshot(time_base));
        end
        drain();

        // Extreme settings: threshold 0 and period 1, then 255 and max period.
        apb_write(3'(4 * RegTrig), 32'd0);
        apb_write(3'(4 * RegPeriod), 32'd1);
        for (int i = 0; i < 5; i++) begin
            time_base = next_time(time_base);
            send_snapshot(rand_snapshot(time_base));
        end
        drain();
        apb_write(3'(4 * RegTrig), 32'd255);
        apb_write(3'(4 * RegPeriod), 32'd65535);
        for (int i = 0; i < 5; i++) begin
            time_base = next_time(time_base);
            send_snapshot(rand_snapshot(time_base));
        end
        drain();

        // Random phases, each with fresh settings.
        for (int ph = 0; ph < 4; ph++) begin
            apb_write(3'(4 * RegTrig), $urandom_range(0, 255));
            apb_write(3'(4 * RegPeriod), $urandom_range(1, 65535));
            if (ph == 3) calm = 1'b1;
            for (int i = 0; i < 24; i++) begin
                time_base = next_time(time_base);
                send_snapshot(rand_snapshot(time_base));
            end
            drain();
        end

        $display("requests sent: %0d, report words checked: %0d", req_count, words_seen);
        $display("covered threshold/period extremes, zero, backward and out-of-range deltas");
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
